// ===== rtl/dcf_pkg.sv =====
// Shared types, constants and the sequencer program for the delimited command framer.
// No dependencies; imported by dcf_store and delimited_command_framer_unit.
`timescale 1ns / 1ps

package dcf_pkg;

    localparam int FRAME_DEPTH_DEF = 32;
    localparam int MAX_RUN         = 31;
    localparam int RUN_W           = $clog2(MAX_RUN + 1);

    localparam logic [7:0] START_MARK = 8'h23;   // '#'
    localparam logic [7:0] END_MARK   = 8'h21;   // '!'
    localparam int         MIN_FRAME  = 2;

    localparam int CMD_FEED = 0;
    localparam int CMD_TAKE = 1;

    typedef enum logic [2:0] {
        STEP_FETCH,
        STEP_FEED,
        STEP_TAKE,
        STEP_READ,
        STEP_EMIT,
        STEP_SINGLE
    } step_t;

    typedef enum logic [1:0] {
        JMP_GOTO,      // go to target
        JMP_WAIT_IN,   // hold until a word is taken, then feed -> target, take -> alt
        JMP_ZERO,      // empty run -> alt, else target
        JMP_OUT        // hold until output slot frees, then last -> target, else alt
    } jump_t;

    typedef struct packed {
        logic  s_ready;
        logic  feed;
        logic  take;
        logic  rd;
        logic  emit_char;
        logic  emit_single;
        jump_t jump;
        step_t target;
        step_t alt;
    } ucode_t;

    // Control store: one control word per step.
    function automatic ucode_t dcf_ucode(input step_t step);
        ucode_t uw;
        uw = '{s_ready: 1'b0, feed: 1'b0, take: 1'b0, rd: 1'b0, emit_char: 1'b0,
               emit_single: 1'b0, jump: JMP_GOTO, target: STEP_FETCH, alt: STEP_FETCH};
        case (step)
            STEP_FETCH: begin
                uw.s_ready = 1'b1;
                uw.jump    = JMP_WAIT_IN;
                uw.target  = STEP_FEED;
                uw.alt     = STEP_TAKE;
            end
            STEP_FEED: begin
                uw.feed   = 1'b1;
                uw.target = STEP_FETCH;
            end
            STEP_TAKE: begin
                uw.take   = 1'b1;
                uw.jump   = JMP_ZERO;
                uw.target = STEP_READ;
                uw.alt    = STEP_SINGLE;
            end
            STEP_READ: begin
                uw.rd     = 1'b1;
                uw.target = STEP_EMIT;
            end
            STEP_EMIT: begin
                uw.emit_char = 1'b1;
                uw.jump      = JMP_OUT;
                uw.target    = STEP_FETCH;
                uw.alt       = STEP_READ;
            end
            STEP_SINGLE: begin
                uw.emit_single = 1'b1;
                uw.jump        = JMP_OUT;
                uw.target      = STEP_FETCH;
                uw.alt         = STEP_FETCH;
            end
            default: begin
                uw.target = STEP_FETCH;
            end
        endcase
        return uw;
    endfunction

endpackage

// ===== rtl/dcf_store.sv =====
// Byte store for the frame being received and the published command.
// One write port, one registered read port; depends on dcf_pkg.
`timescale 1ns / 1ps

module dcf_store #(
    parameter int DEPTH = dcf_pkg::FRAME_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);
    import dcf_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/delimited_command_framer_unit.sv =====
// Top level of the delimited command framer: microcoded sequencer, frame datapath, output slot.
// Depends on dcf_pkg and dcf_store.
`timescale 1ns / 1ps

// Receives command frames that open with '#' and close with '!' and keeps one finished
// command in a single slot until it is taken. Each input word is either a feed (s_tuser 0,
// one received byte in s_tdata[7:0]) or a take (s_tuser 1, reader buffer size in
// s_tdata[15:8]). A feed gives no result and passes through the fetch step and the update
// step. A take returns a run of result words with one command character each,
// cut to size minus one and to 31 characters, with m_tlast on the final word; when there is
// no command, or the size leaves no room, it returns one word with m_tuser[1] low. A take of
// n characters passes through the fetch and take steps, then a read step and an emit step
// for each character (one single step for a single word), as the read of the shared byte
// store is registered: one step reads a character, the next places it in the output
// register. Back pressure on m_tready holds the emit and single steps until it frees.
// While a command waits in the slot, fed bytes are ignored. FRAME_DEPTH sets the byte store
// depth; a frame keeps at most FRAME_DEPTH - 1 bytes including both marks.
module delimited_command_framer_unit #(
    parameter int FRAME_DEPTH = dcf_pkg::FRAME_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] rx_byte, [15:8] out_size
    input  logic        s_tuser,    // [0] cmd
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] char_byte
    output logic [1:0]  m_tuser,    // [0] command_found, [1] char_valid
    output logic        m_tlast     // last
);
    import dcf_pkg::*;

    localparam int                ADDR_W = $clog2(FRAME_DEPTH);
    localparam logic [ADDR_W-1:0] LIMIT  = ADDR_W'(FRAME_DEPTH - 1);

    // ---------------------------------------------------------------
    // Sequencer: step counter and control word
    // ---------------------------------------------------------------
    step_t  step_reg, step_next;
    ucode_t uw;

    logic s_accept;
    logic out_free;
    logic run_last;
    logic run_zero;

    // latched input word
    logic [7:0] rx_reg;
    logic [7:0] size_reg;

    // frame and command state
    logic              in_frame_reg, in_frame_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic              ready_reg, ready_next;
    logic [ADDR_W-1:0] len_reg, len_next;

    // readout state
    logic [RUN_W-1:0] n_reg;
    logic [RUN_W-1:0] idx_reg;
    logic             found_reg;
    logic [RUN_W-1:0] n_calc;
    logic             found_calc;
    logic [7:0]       size_m1;
    logic [7:0]       len_ext;
    logic [7:0]       min8;

    // store ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        rd_data;

    // output slot
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic [1:0] m_user_reg;
    logic       m_last_reg;

    assign uw       = dcf_ucode(step_reg);
    assign s_tready = uw.s_ready;
    assign s_accept = s_tvalid && uw.s_ready;
    assign out_free = !m_valid_reg || m_tready;
    assign run_last = (idx_reg + RUN_W'(1)) == n_reg;
    assign run_zero = (n_calc == '0);

    // next step
    always_comb begin
        step_next = step_reg;
        case (uw.jump)
            JMP_GOTO: begin
                step_next = uw.target;
            end
            JMP_WAIT_IN: begin
                if (s_accept) begin
                    step_next = (s_tuser == 1'(CMD_TAKE)) ? uw.alt : uw.target;
                end
            end
            JMP_ZERO: begin
                step_next = run_zero ? uw.alt : uw.target;
            end
            JMP_OUT: begin
                if (out_free) begin
                    step_next = (uw.emit_single || run_last) ? uw.target : uw.alt;
                end
            end
            default: begin
                step_next = STEP_FETCH;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

    // hold the accepted word for the following steps
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rx_reg   <= s_tdata[7:0];
            size_reg <= s_tdata[15:8];
        end
    end

    // ---------------------------------------------------------------
    // Take: run length = min(length, size - 1, MAX_RUN); empty slot or
    // zero size gives a not-found word
    // ---------------------------------------------------------------
    assign found_calc = ready_reg && (size_reg != 8'd0);
    assign size_m1    = size_reg - 8'd1;
    assign len_ext    = 8'(len_reg);
    assign min8       = (len_ext < size_m1) ? len_ext : size_m1;

    always_comb begin
        if (!found_calc) begin
            n_calc = '0;
        end else if (min8 > 8'(MAX_RUN)) begin
            n_calc = RUN_W'(MAX_RUN);
        end else begin
            n_calc = min8[RUN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (uw.take) begin
            n_reg     <= n_calc;
            found_reg <= found_calc;
            idx_reg   <= '0;
        end else if (uw.emit_char && out_free) begin
            idx_reg <= idx_reg + RUN_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // Feed: frame tracking and the store write
    // ---------------------------------------------------------------
    always_comb begin
        in_frame_next = in_frame_reg;
        fill_next     = fill_reg;
        ready_next    = ready_reg;
        len_next      = len_reg;
        wr_en         = 1'b0;
        wr_addr       = fill_reg;

        if (uw.feed && !ready_reg) begin
            if (!in_frame_reg) begin
                // drop bytes until a start mark
                if (rx_reg == START_MARK) begin
                    wr_en         = 1'b1;
                    wr_addr       = '0;
                    fill_next     = ADDR_W'(1);
                    in_frame_next = 1'b1;
                end
            end else if (rx_reg == END_MARK) begin
                // close; publish only when the end mark fits
                if (fill_reg < LIMIT) begin
                    wr_en = 1'b1;
                    if ((32'(fill_reg) + 32'd1) >= 32'(MIN_FRAME)) begin
                        len_next   = fill_reg + ADDR_W'(1);
                        ready_next = 1'b1;
                    end
                end
                in_frame_next = 1'b0;
                fill_next     = '0;
            end else if (rx_reg == START_MARK) begin
                // restart the frame
                wr_en     = 1'b1;
                wr_addr   = '0;
                fill_next = ADDR_W'(1);
            end else if (fill_reg < LIMIT) begin
                wr_en     = 1'b1;
                fill_next = fill_reg + ADDR_W'(1);
            end else begin
                // overflow: drop the frame
                in_frame_next = 1'b0;
                fill_next     = '0;
            end
        end

        if (uw.take && found_calc) begin
            ready_next = 1'b0;
            len_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            fill_reg     <= '0;
            ready_reg    <= 1'b0;
            len_reg      <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            fill_reg     <= fill_next;
            ready_reg    <= ready_next;
            len_reg      <= len_next;
        end
    end

    // frame bytes and the published command share one store: while the
    // slot is full no byte is written, so the command stays intact
    dcf_store #(
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_reg),
        .rd_en   (uw.rd),
        .rd_addr (ADDR_W'(idx_reg)),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Output slot
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((uw.emit_char || uw.emit_single) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (uw.emit_char && out_free) begin
            m_data_reg <= rd_data;
            m_user_reg <= 2'b11;
            m_last_reg <= run_last;
        end else if (uw.emit_single && out_free) begin
            m_data_reg <= 8'd0;
            m_user_reg <= {1'b0, found_reg};
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_slot_blocks_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> !in_frame_reg)
        else $error("frame in progress while command slot is full");

    a_publish_from_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ready_reg) |-> $past(step_reg) == STEP_FEED)
        else $error("command published outside a feed step");

    a_run_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == STEP_READ || step_reg == STEP_EMIT) |-> idx_reg < n_reg)
        else $error("readout index past run length");

    a_char_implies_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg[1]) |-> m_user_reg[0])
        else $error("character word without a found command");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> fill_reg == '0)
        else $error("fill count left over outside a frame");

endmodule
